[rtl/core/lpt_pkg.sv]
package lpt_pkg;

	localparam int LPT_TABLE_DEPTH = 1024;
	localparam int LPT_PPN_BITS    = 20;
	localparam int LPT_QDEPTH      = 2;

	localparam logic       OP_ACCESS = 1'b0;
	localparam logic       OP_LOAD   = 1'b1;

	localparam logic [1:0] SZ_2 = 2'd1;
	localparam logic [1:0] SZ_4 = 2'd2;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_BUS   = 3'd1;
	localparam logic [2:0] ST_ADDR  = 3'd2;
	localparam logic [2:0] ST_RO    = 3'd3;
	localparam logic [2:0] ST_FAULT = 3'd4;

	localparam logic [1:0] CFG_PAGE_SHIFT  = 2'd0;
	localparam logic [1:0] CFG_TABLE_PAGES = 2'd1;
	localparam logic [1:0] CFG_PHYS_PAGES  = 2'd2;

	localparam logic [4:0]  RST_PAGE_SHIFT  = 5'd12;
	localparam logic [10:0] RST_TABLE_PAGES = 11'd1024;
	localparam logic [20:0] RST_PHYS_PAGES  = 21'd1024;

	typedef struct packed {
		logic        is_load;
		logic        idx_ok;
		logic        misalign;
		logic        is_write;
		logic [31:0] offset;
		logic [19:0] load_ppn;
		logic        load_rd;
		logic        load_wr;
		logic        load_valid;
	} lpt_item_t;

endpackage

[rtl/core/lpt_front.sv]
module lpt_front import lpt_pkg::*; #(
	parameter int TABLE_DEPTH = LPT_TABLE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               enable,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               operation,
	input  logic [31:0]                        virt_addr,
	input  logic [1:0]                         size_code,
	input  logic                               is_write,
	input  logic [9:0]                         entry_index,
	input  logic [19:0]                        entry_phys_page,
	input  logic                               entry_read_ok,
	input  logic                               entry_write_ok,
	input  logic                               entry_valid,
	input  logic [4:0]                         page_shift,
	input  logic [10:0]                        table_pages,
	output logic                               q_valid,
	input  logic                               q_ready,
	output lpt_item_t                          q_item,
	output logic [$clog2(TABLE_DEPTH)-1:0]     q_idx
);

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int QPTR_W = $clog2(LPT_QDEPTH);
	localparam int QCNT_W = $clog2(LPT_QDEPTH + 1);

	lpt_item_t            item_q [LPT_QDEPTH];
	logic [IDX_W-1:0]     idx_q  [LPT_QDEPTH];
	logic [QPTR_W-1:0]    wptr_q;
	logic [QPTR_W-1:0]    rptr_q;
	logic [QCNT_W-1:0]    cnt_q;

	lpt_item_t            cls_item;
	logic [IDX_W-1:0]     cls_idx;
	logic [31:0]          vpn;
	logic [31:0]          limit;
	logic [31:0]          load_idx32;
	logic                 push;
	logic                 pop;

	// classify the incoming beat
	always_comb begin
		vpn        = virt_addr >> page_shift;
		limit      = (32'(table_pages) < 32'(TABLE_DEPTH)) ? 32'(table_pages)
		                                                   : 32'(TABLE_DEPTH);
		load_idx32 = 32'(entry_index);

		cls_item.is_load    = (operation == OP_LOAD);
		cls_item.is_write   = is_write;
		cls_item.offset     = virt_addr & ~(32'hFFFF_FFFF << page_shift);
		cls_item.load_ppn   = entry_phys_page;
		cls_item.load_rd    = entry_read_ok;
		cls_item.load_wr    = entry_write_ok;
		cls_item.load_valid = entry_valid;

		if (operation == OP_LOAD) begin
			cls_item.idx_ok   = load_idx32 < 32'(TABLE_DEPTH);
			cls_item.misalign = 1'b0;
			cls_idx           = load_idx32[IDX_W-1:0];
		end else begin
			cls_item.idx_ok   = vpn < limit;
			cls_item.misalign = ((size_code == SZ_4) && (virt_addr[1:0] != 2'b00)) ||
			                    ((size_code == SZ_2) && virt_addr[0]);
			cls_idx           = vpn[IDX_W-1:0];
		end
	end

	assign in_ready = enable && (cnt_q != QCNT_W'(LPT_QDEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_valid && q_ready;
	assign q_item   = item_q[rptr_q];
	assign q_idx    = idx_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wptr_q] <= cls_item;
			idx_q[wptr_q]  <= cls_idx;
		end
	end

endmodule

[rtl/core/lpt_back.sv]
module lpt_back import lpt_pkg::*; #(
	parameter int TABLE_DEPTH = LPT_TABLE_DEPTH,
	parameter int PPN_BITS    = LPT_PPN_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	output logic                               q_ready,
	input  lpt_item_t                          q_item,
	input  logic [$clog2(TABLE_DEPTH)-1:0]     q_idx,
	input  logic [4:0]                         page_shift,
	input  logic [20:0]                        phys_pages,
	output logic                               clear_busy,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [2:0]                         status,
	output logic [31:0]                        phys_addr,
	output logic                               used_mark,
	output logic                               modified_mark
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int EW    = PPN_BITS + 5;

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} back_state_t;

	back_state_t          state_q;
	logic [IDX_W-1:0]     clr_q;
	lpt_item_t            item_q;
	logic [IDX_W-1:0]     idx_q;
	logic [EW-1:0]        rdata_q;
	logic [EW-1:0]        mem [TABLE_DEPTH];

	logic                 out_valid_q;
	logic [2:0]           status_q;
	logic [31:0]          pa_q;
	logic                 used_q;
	logic                 mod_q;

	logic [PPN_BITS-1:0]  e_ppn;
	logic                 e_rd;
	logic                 e_wr;
	logic                 e_vld;
	logic                 e_used;
	logic                 e_mod;
	logic [31:0]          ppn_in32;
	logic [31:0]          e_ppn32;
	logic                 fire;
	logic                 upd_we;
	logic [EW-1:0]        upd_data;
	logic [2:0]           res_status;
	logic [31:0]          res_pa;
	logic                 res_used;
	logic                 res_mod;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [EW-1:0]        mem_wdata;

	assign q_ready    = (state_q == S_IDLE);
	assign clear_busy = (state_q == S_CLEAR);
	assign fire       = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	// check and update one entry
	always_comb begin
		e_ppn    = rdata_q[EW-1:5];
		e_rd     = rdata_q[4];
		e_wr     = rdata_q[3];
		e_vld    = rdata_q[2];
		e_used   = rdata_q[1];
		e_mod    = rdata_q[0];
		ppn_in32 = 32'(item_q.load_ppn);
		e_ppn32  = 32'(e_ppn);

		res_status = ST_OK;
		res_pa     = '0;
		res_used   = 1'b0;
		res_mod    = 1'b0;
		upd_we     = 1'b0;
		upd_data   = rdata_q;

		if (item_q.is_load) begin
			if (item_q.idx_ok) begin
				upd_we   = 1'b1;
				upd_data = {ppn_in32[PPN_BITS-1:0], item_q.load_rd, item_q.load_wr,
				            item_q.load_valid, 1'b0, 1'b0};
			end else begin
				res_status = ST_ADDR;
			end
		end else if (!item_q.idx_ok) begin
			res_status = item_q.misalign ? ST_BUS : ST_ADDR;
		end else begin
			res_used = e_used;
			res_mod  = e_mod;
			if (item_q.misalign) begin
				res_status = ST_BUS;
			end else if (!e_rd && !e_wr) begin
				res_status = ST_ADDR;
			end else if (item_q.is_write && !e_wr) begin
				res_status = ST_RO;
			end else if (!e_vld) begin
				res_status = ST_FAULT;
			end else if (33'(e_ppn) >= 33'(phys_pages)) begin
				res_status = ST_BUS;
			end else begin
				res_used = 1'b1;
				res_mod  = e_mod || item_q.is_write;
				upd_we   = 1'b1;
				upd_data = {e_ppn, e_rd, e_wr, e_vld, 1'b1, res_mod};
				res_pa   = (e_ppn32 << page_shift) + item_q.offset;
			end
		end
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = fire && upd_we;
			mem_waddr = idx_q;
			mem_wdata = upd_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (q_valid && q_ready) begin
			rdata_q <= mem[q_idx];
			item_q  <= q_item;
			idx_q   <= q_idx;
		end
		if (fire) begin
			status_q <= res_status;
			pa_q     <= res_pa;
			used_q   <= res_used;
			mod_q    <= res_mod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign phys_addr     = pa_q;
	assign used_mark     = used_q;
	assign modified_mark = mod_q;

endmodule

[rtl/core/linear_page_table_translate.sv]
// path: an input beat goes through the queue, the table read and the check
// the back end takes no new item until the read-modify-write of the last entry ends
// reset: a clearing pass writes zero to every table entry, one per cycle, TABLE_DEPTH
// entries (1024 by default); no input beat is taken until it ends
// configuration writes are taken in any cycle, registers return to their reset values
module linear_page_table_translate import lpt_pkg::*; #(
	parameter int TABLE_DEPTH = LPT_TABLE_DEPTH,
	parameter int PPN_BITS    = LPT_PPN_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [31:0] virt_addr,
	input  logic [1:0]  size_code,
	input  logic        is_write,
	input  logic [9:0]  entry_index,
	input  logic [19:0] entry_phys_page,
	input  logic        entry_read_ok,
	input  logic        entry_write_ok,
	input  logic        entry_valid,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] phys_addr,
	output logic        used_mark,
	output logic        modified_mark,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [20:0] cfg_data
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	logic [4:0]       page_shift_q;
	logic [10:0]      table_pages_q;
	logic [20:0]      phys_pages_q;

	logic             q_valid;
	logic             q_ready;
	lpt_item_t        q_item;
	logic [IDX_W-1:0] q_idx;
	logic             clear_busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_shift_q  <= RST_PAGE_SHIFT;
			table_pages_q <= RST_TABLE_PAGES;
			phys_pages_q  <= RST_PHYS_PAGES;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PAGE_SHIFT:  page_shift_q  <= cfg_data[4:0];
				CFG_TABLE_PAGES: table_pages_q <= cfg_data[10:0];
				CFG_PHYS_PAGES:  phys_pages_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lpt_front #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.enable          (!clear_busy),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.virt_addr       (virt_addr),
		.size_code       (size_code),
		.is_write        (is_write),
		.entry_index     (entry_index),
		.entry_phys_page (entry_phys_page),
		.entry_read_ok   (entry_read_ok),
		.entry_write_ok  (entry_write_ok),
		.entry_valid     (entry_valid),
		.page_shift      (page_shift_q),
		.table_pages     (table_pages_q),
		.q_valid         (q_valid),
		.q_ready         (q_ready),
		.q_item          (q_item),
		.q_idx           (q_idx)
	);

	lpt_back #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.PPN_BITS   (PPN_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_item        (q_item),
		.q_idx         (q_idx),
		.page_shift    (page_shift_q),
		.phys_pages    (phys_pages_q),
		.clear_busy    (clear_busy),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.phys_addr     (phys_addr),
		.used_mark     (used_mark),
		.modified_mark (modified_mark)
	);

endmodule
